### hdl/agsc_pkg.sv
// Types and constants shared by the gain and soft clip blocks.
// No dependencies.
package agsc_pkg;

    localparam int NUM_CH     = 2;
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_REG_W = 17;
    localparam int CHCNT_W    = 2;
    localparam int GAINED_W   = 25;
    localparam int NUM_W      = 40;
    localparam int PCM_W      = 16;
    localparam int DIV_STEPS  = 15;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CHCNT_W-1:0]    CHCNT_RESET = 2'd2;
    localparam logic [CHCNT_W-1:0]    CH_MONO     = 2'd1;
    localparam logic [GAIN_REG_W-1:0] GAIN_RESET  = 17'h10000;
    localparam logic [GAINED_W-1:0]   FULL_SCALE  = 25'h100000;

    localparam logic REG_CHANNEL_COUNT = 1'b0;
    localparam logic REG_VOLUME_GAIN   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAINED_W-1:0] gained_t;

    typedef struct packed {
        logic signed [23:0] left_sample;
        logic signed [23:0] right_sample;
        logic [1:0]         channels_provided;
        logic               buffer_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pcm_left;
        logic signed [15:0] pcm_right;
        logic               buffer_end_out;
    } out_item_t;

    typedef struct packed {
        logic                  mono;
        logic [GAIN_REG_W-1:0] gain;
    } cfg_t;

    // gained samples, index 0 left, index 1 right
    typedef struct packed {
        gained_t [NUM_CH-1:0] v;
        logic                 buffer_end;
    } frame_v_t;

    typedef struct packed {
        logic                 neg;
        logic [GAINED_W-1:0]  den;
        logic [GAINED_W-1:0]  rem;
        logic [DIV_STEPS-1:0] low;
        logic [DIV_STEPS-1:0] quo;
    } lane_t;

endpackage

### hdl/audio_gain_soft_clip_pcm16.sv
// Stereo gain and sigmoid soft clip to 16-bit PCM.
// Throughput: one frame per cycle while the output is not stalled; the 15-stage divider pipeline sets the latency.
// Reset (aresetn low, synchronous) empties the pipeline and queue, channel_count = 2,
// volume_gain = 65536. Depends on agsc_pkg, agsc_regs, agsc_front, agsc_queue, agsc_back.
module audio_gain_soft_clip_pcm16 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [agsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [agsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [agsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  agsc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output agsc_pkg::out_item_t              m_data
);
    import agsc_pkg::*;

    cfg_t     cfg;
    logic     q_push;
    logic     q_ready;
    frame_v_t q_wdata;
    logic     q_pop;
    logic     q_valid;
    frame_v_t q_rdata;

    agsc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    agsc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_ready (q_ready),
        .q_data  (q_wdata)
    );

    agsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_ready (q_ready),
        .wr_data  (q_wdata),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_rdata)
    );

    agsc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_rdata),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pcm_left >= -16'sd32766 && m_data.pcm_left <= 16'sd32766))
        else $error("pcm_left outside soft clip range");

    a_right_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.pcm_right >= -16'sd32766 && m_data.pcm_right <= 16'sd32766))
        else $error("pcm_right outside soft clip range");

    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> !q_ready)
        else $error("front end stalled while queue has room");

endmodule

### hdl/agsc_regs.sv
// APB register file: channel count and Q16 volume gain.
// Depends on agsc_pkg.
module agsc_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [agsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [agsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [agsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output agsc_pkg::cfg_t                   cfg
);
    import agsc_pkg::*;

    logic [CHCNT_W-1:0]    chcnt_reg;
    logic [GAIN_REG_W-1:0] gain_reg;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chcnt_reg <= CHCNT_RESET;
            gain_reg  <= GAIN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_CHANNEL_COUNT: chcnt_reg <= pwdata[CHCNT_W-1:0];
                REG_VOLUME_GAIN:   gain_reg  <= pwdata[GAIN_REG_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CHANNEL_COUNT: prdata = APB_DATA_W'(chcnt_reg);
            REG_VOLUME_GAIN:   prdata = APB_DATA_W'(gain_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.mono = (chcnt_reg == CH_MONO);
    assign cfg.gain = gain_reg;

endmodule

### hdl/agsc_front.sv
// Front end: takes input transfers, mutes unused channels, applies the Q16 gain.
// Depends on agsc_pkg.
module agsc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  agsc_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  agsc_pkg::in_item_t   s_data,
    output logic                 q_push,
    input  logic                 q_ready,
    output agsc_pkg::frame_v_t   q_data
);
    import agsc_pkg::*;

    logic                vld_reg;
    sample_t             x_reg [NUM_CH];
    logic                be_reg;
    logic                accept;
    logic                left_on;
    logic                right_on;
    logic signed [41:0]  prod [NUM_CH];

    assign s_ready  = !vld_reg || q_ready;
    assign accept   = s_valid && s_ready;
    assign left_on  = (s_data.channels_provided != 2'd0);
    assign right_on = s_data.channels_provided[1] && !cfg.mono;
    assign q_push   = vld_reg && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg[0] <= left_on  ? s_data.left_sample  : '0;
            x_reg[1] <= right_on ? s_data.right_sample : '0;
            be_reg   <= s_data.buffer_end_in;
        end
    end

    // floor shift by 16 is an arithmetic slice of the product
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            prod[c]   = 42'(x_reg[c]) * 42'($signed({1'b0, cfg.gain}));
            q_data.v[c] = prod[c][40:16];
        end
        q_data.buffer_end = be_reg;
    end

endmodule

### hdl/agsc_queue.sv
// Short register queue between front end and soft clip pipeline.
// Depends on agsc_pkg.
module agsc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    output logic                wr_ready,
    input  agsc_pkg::frame_v_t  wr_data,
    input  logic                pop,
    output logic                rd_valid,
    output agsc_pkg::frame_v_t  rd_data
);
    import agsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_v_t           mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_push  = push && wr_ready;
    assign do_pop   = pop && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/agsc_back.sv
// Back end: soft clip 32767*|v|/(2^20+|v|) as a pipelined restoring divider,
// one quotient bit per stage, then the output register. Depends on agsc_pkg.
module agsc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_pop,
    input  agsc_pkg::frame_v_t  q_data,
    output logic                m_valid,
    input  logic                m_ready,
    output agsc_pkg::out_item_t m_data
);
    import agsc_pkg::*;

    lane_t             lane_reg [DIV_STEPS+1][NUM_CH];
    logic              be_reg   [DIV_STEPS+1];
    logic              vld_reg  [DIV_STEPS+1];
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    logic              en;

    function automatic lane_t lane_init(input gained_t v);
        logic [GAINED_W-1:0] mag;
        logic [NUM_W-1:0]    num;
        lane_t               l;
        mag   = v[GAINED_W-1] ? GAINED_W'(-v) : GAINED_W'(v);
        num   = {mag, 15'b0} - NUM_W'(mag);
        l.neg = v[GAINED_W-1];
        l.den = mag + FULL_SCALE;
        l.rem = {1'b0, num[38:DIV_STEPS]};
        l.low = num[DIV_STEPS-1:0];
        l.quo = '0;
        return l;
    endfunction

    function automatic lane_t lane_step(input lane_t l);
        logic [GAINED_W:0] t;
        logic              qb;
        lane_t             o;
        o  = l;
        t  = {l.rem, l.low[DIV_STEPS-1]};
        qb = (t >= {1'b0, l.den});
        o.rem = qb ? GAINED_W'(t - {1'b0, l.den}) : t[GAINED_W-1:0];
        o.low = {l.low[DIV_STEPS-2:0], 1'b0};
        o.quo = {l.quo[DIV_STEPS-2:0], qb};
        return o;
    endfunction

    function automatic logic [PCM_W-1:0] to_pcm(input lane_t l);
        logic [PCM_W-1:0] q;
        q = {1'b0, l.quo};
        return l.neg ? -q : q;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                vld_reg[k] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= q_valid;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
            m_valid_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                lane_reg[0][c] <= lane_init(q_data.v[c]);
                for (int k = 1; k <= DIV_STEPS; k++) begin
                    lane_reg[k][c] <= lane_step(lane_reg[k-1][c]);
                end
            end
            be_reg[0] <= q_data.buffer_end;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                be_reg[k] <= be_reg[k-1];
            end
            m_data_reg.pcm_left       <= to_pcm(lane_reg[DIV_STEPS][0]);
            m_data_reg.pcm_right      <= to_pcm(lane_reg[DIV_STEPS][1]);
            m_data_reg.buffer_end_out <= be_reg[DIV_STEPS];
        end
    end

endmodule

### test/audio_gain_soft_clip_pcm16_test.sv
`timescale 1ns / 1ps
// Testbench for audio_gain_soft_clip_pcm16: drives frames and configuration writes and
// checks every PCM frame against its own gain and soft clip predictor.
// Depends on agsc_pkg and the audio_gain_soft_clip_pcm16 RTL.
module audio_gain_soft_clip_pcm16_test;

    import agsc_pkg::*;

    localparam logic [CHCNT_W-1:0] CH_STEREO = 2'd2;
    localparam int GAIN_SHIFT = 16;
    localparam longint PCM_SCALE = 32767;
    localparam longint UNITY_SAMPLE = 64'sd1 << 20;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    in_item_t frame_q[$];
    out_item_t pcm_expected_q[$];
    out_item_t pcm_due;
    bit frame_taken = 1'b0;
    bit failed = 1'b0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;

    logic [CHCNT_W-1:0] cfg_channel_count = CHCNT_RESET;
    logic [GAIN_REG_W-1:0] cfg_volume_gain = GAIN_RESET;

    audio_gain_soft_clip_pcm16 u_top (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // gain with floor shift, then trunc(32767 * v / (2^20 + |v|))
    function automatic logic signed [15:0] pcm_of_sample(logic signed [23:0] x,
                                                         logic [GAIN_REG_W-1:0] gain);
        longint p;
        longint v;
        longint mag;
        longint q;
        p = longint'(x) * longint'(gain);
        v = p >>> GAIN_SHIFT;
        mag = (v < 0) ? -v : v;
        q = (PCM_SCALE * mag) / (UNITY_SAMPLE + mag);
        return 16'((v < 0) ? -q : q);
    endfunction

    function automatic out_item_t predict_pcm_frame(in_item_t f);
        out_item_t o;
        o = '0;
        if (f.channels_provided >= 2'd1)
            o.pcm_left = pcm_of_sample(f.left_sample, cfg_volume_gain);
        if (f.channels_provided >= 2'd2 && cfg_channel_count != CH_MONO)
            o.pcm_right = pcm_of_sample(f.right_sample, cfg_volume_gain);
        o.buffer_end_out = f.buffer_end_in;
        return o;
    endfunction

    function automatic logic signed [23:0] pick_sample();
        logic signed [23:0] s;
        s = 24'($urandom);
        case ($urandom_range(5))
            0: s = 24'($urandom_range(4095));
            1: s = 24'(UNITY_SAMPLE + longint'($urandom_range(4096)) - 2048);
            2: s = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
            default: ;
        endcase
        if ($urandom_range(3) == 0)
            s = -s;
        return s;
    endfunction

    task automatic push_frame(logic signed [23:0] l, logic signed [23:0] r,
                              logic [1:0] provided, logic last);
        in_item_t f;
        f.left_sample = l;
        f.right_sample = r;
        f.channels_provided = provided;
        f.buffer_end_in = last;
        frame_q.push_back(f);
    endtask

    task automatic apb_write(logic index, logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_CHANNEL_COUNT)
            cfg_channel_count = value[CHCNT_W-1:0];
        else
            cfg_volume_gain = value[GAIN_REG_W-1:0];
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (frame_q.size() != 0 || s_valid || pcm_expected_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(logic [CHCNT_W-1:0] ch_count, logic [GAIN_REG_W-1:0] gain,
                             int send_pct, int stall_pct, int n_frames);
        int burst;
        apb_write(REG_CHANNEL_COUNT, APB_DATA_W'(ch_count));
        apb_write(REG_VOLUME_GAIN, APB_DATA_W'(gain));
        send_idle_pct = send_pct;
        sink_stall_pct = stall_pct;
        while (n_frames > 0) begin
            burst = $urandom_range(40, 1);
            if (burst > n_frames)
                burst = n_frames;
            n_frames -= burst;
            repeat (burst) begin
                push_frame(pick_sample(), pick_sample(),
                           ($urandom_range(3) == 0) ? 2'($urandom) : 2'd2, 1'($urandom));
            end
            // occasionally hold the sender until the pipeline has emptied
            if ($urandom_range(3) == 0)
                wait_drained();
            else
                while (frame_q.size() != 0) @(negedge aclk);
        end
        wait_drained();
    endtask

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || frame_taken) begin
            if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= frame_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        frame_taken = aresetn && s_valid && s_ready;
        if (frame_taken)
            pcm_expected_q.push_back(predict_pcm_frame(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (pcm_expected_q.size() == 0) begin
                $error("unexpected PCM transfer %p", m_data);
                failed = 1'b1;
            end else begin
                pcm_due = pcm_expected_q.pop_front();
                if (m_data.pcm_left !== pcm_due.pcm_left) begin
                    $error("pcm_left: expected %0d, got %0d", pcm_due.pcm_left, m_data.pcm_left);
                    failed = 1'b1;
                end
                if (m_data.pcm_right !== pcm_due.pcm_right) begin
                    $error("pcm_right: expected %0d, got %0d",
                           pcm_due.pcm_right, m_data.pcm_right);
                    failed = 1'b1;
                end
                if (m_data.buffer_end_out !== pcm_due.buffer_end_out) begin
                    $error("buffer_end_out: expected %0b, got %0b",
                           pcm_due.buffer_end_out, m_data.buffer_end_out);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset config, stereo at unity gain
        push_frame(24'sd0, 24'sd0, 2'd2, 1'b0);
        push_frame(24'sh7fffff, 24'sh800000, 2'd2, 1'b1);
        push_frame(24'sh800000, 24'sh7fffff, 2'd2, 1'b0);
        push_frame(24'sd1, -24'sd1, 2'd2, 1'b0);
        push_frame(24'sh100000, -24'sh100000, 2'd2, 1'b1);
        push_frame(24'sh7fffff, 24'sh7fffff, 2'd0, 1'b1);
        push_frame(24'sh7fffff, 24'sh800000, 2'd1, 1'b0);
        push_frame(24'sh800000, 24'sh800000, 2'd3, 1'b1);
        push_frame(24'sd12345, -24'sd54321, 2'd2, 1'b0);
        push_frame(24'sd16, -24'sd16, 2'd2, 1'b0);
        push_frame(24'sh0fffff, -24'sh0fffff, 2'd2, 1'b1);
        wait_drained();

        // directed: mono with maximum gain
        apb_write(REG_CHANNEL_COUNT, APB_DATA_W'(CH_MONO));
        apb_write(REG_VOLUME_GAIN, APB_DATA_W'(17'h1ffff));
        push_frame(24'sh7fffff, 24'sh7fffff, 2'd2, 1'b0);
        push_frame(24'sh800000, 24'sh800000, 2'd3, 1'b1);
        push_frame(24'sd1, -24'sd1, 2'd1, 1'b0);
        push_frame(24'sh100000, 24'sh100000, 2'd0, 1'b1);
        wait_drained();

        // directed: stereo with zero gain, then gain 1, at odd channel counts
        apb_write(REG_CHANNEL_COUNT, APB_DATA_W'(2'd0));
        apb_write(REG_VOLUME_GAIN, APB_DATA_W'(17'd0));
        push_frame(24'sh7fffff, 24'sh800000, 2'd2, 1'b1);
        push_frame(-24'sd1, 24'sd1, 2'd3, 1'b0);
        wait_drained();
        apb_write(REG_CHANNEL_COUNT, APB_DATA_W'(2'd3));
        apb_write(REG_VOLUME_GAIN, APB_DATA_W'(17'd1));
        push_frame(24'sh7fffff, 24'sh800000, 2'd2, 1'b0);
        push_frame(-24'sd1, 24'sd1, 2'd2, 1'b1);
        wait_drained();

        run_phase(CH_MONO, GAIN_RESET, 0, 0, 108);
        run_phase(CH_STEREO, 17'd0, 50, 0, 108);
        run_phase(CH_STEREO, 17'h1ffff, 0, 50, 108);
        run_phase(2'd0, 17'd1, 33, 33, 108);
        run_phase(2'd3, 17'($urandom), 0, 0, 108);
        run_phase(CH_MONO, 17'd65535, 33, 33, 108);
        run_phase(CH_STEREO, GAIN_RESET, 50, 50, 108);

        sink_stall_pct = 0;
        repeat (40) @(negedge aclk);
        if (!failed)
            $display("audio_gain_soft_clip_pcm16 test passed");
        else
            $display("audio_gain_soft_clip_pcm16 test failed");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("audio_gain_soft_clip_pcm16 test failed");
        $finish;
    end

endmodule
